### hw/rtl/stack_with_dup_swap_rot_macros.svh
// Assertion helpers, sampled on clk and quiet during reset.
`ifndef STACK_WITH_DUP_SWAP_ROT_MACROS_SVH
`define STACK_WITH_DUP_SWAP_ROT_MACROS_SVH

`define SWDR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define SWDR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/swdr_pkg.sv
`default_nettype none

package swdr_pkg;

  localparam int OP_W  = 3;
  localparam int OFF_W = 6;
  localparam int ST_W  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH = 3'd0,
    OP_POP  = 3'd1,
    OP_DUP  = 3'd2,
    OP_SWAP = 3'd3,
    OP_ROT  = 3'd4,
    OP_PEEK = 3'd5
  } op_t;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_UNDER = 2'd1;
  localparam logic [ST_W-1:0] ST_OVER  = 2'd2;

  typedef struct packed {
    logic load;
    logic rd_issue;
    logic rd_latch;
    logic wr_en;
    logic step_clr;
    logic step_inc;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic has_read;
    logic has_write;
    logic last_read;
    logic last_write;
  } sts_t;

endpackage

`default_nettype wire

### hw/rtl/swdr_ram.sv
`default_nettype none

module swdr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                           clk,
  input  wire logic                           we,
  input  wire logic [$clog2(DEPTH)-1:0]       waddr,
  input  wire logic [WIDTH-1:0]               wdata,
  input  wire logic                           re,
  input  wire logic [$clog2(DEPTH)-1:0]       raddr,
  output logic      [WIDTH-1:0]               rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/swdr_ctrl.sv
`default_nettype none

module swdr_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire swdr_pkg::sts_t sts,
  output swdr_pkg::cmd_t      cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DEC   = 6'b000010,
    S_READ  = 6'b000100,
    S_LATCH = 6'b001000,
    S_WRITE = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        cmd.step_clr = 1'b1;
        if (sts.has_read) begin
          state_nxt = S_READ;
        end else if (sts.has_write) begin
          state_nxt = S_WRITE;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_LATCH;
      end
      S_LATCH: begin
        cmd.rd_latch = 1'b1;
        if (!sts.last_read) begin
          cmd.step_inc = 1'b1;
          state_nxt    = S_READ;
        end else if (sts.has_write) begin
          cmd.step_clr = 1'b1;
          state_nxt    = S_WRITE;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_WRITE: begin
        cmd.wr_en = 1'b1;
        if (sts.last_write) begin
          state_nxt = S_DONE;
        end else begin
          cmd.step_inc = 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/swdr_dp.sv
`default_nettype none

module swdr_dp #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire swdr_pkg::cmd_t                cmd,
  output swdr_pkg::sts_t                     sts,
  input  wire logic [swdr_pkg::OP_W-1:0]     in_opcode,
  input  wire logic [DATA_WIDTH-1:0]         in_push_value,
  input  wire logic [swdr_pkg::OFF_W-1:0]    in_peek_offset,
  output logic      [DATA_WIDTH-1:0]         out_read_value,
  output logic      [swdr_pkg::ST_W-1:0]     out_status,
  output logic      [$clog2(DEPTH+1)-1:0]    out_item_count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > swdr_pkg::OFF_W) ? CW : swdr_pkg::OFF_W;

  logic [swdr_pkg::OP_W-1:0]  op_r;
  logic [DATA_WIDTH-1:0]      val_r;
  logic [swdr_pkg::OFF_W-1:0] off_r;
  logic [CW-1:0]              count_r;
  logic [1:0]                 step_r;
  logic [DATA_WIDTH-1:0]      w_r [3];
  logic [DATA_WIDTH-1:0]      rv_r;
  logic [swdr_pkg::ST_W-1:0]  st_r;

  logic [1:0]                 rd_n, wr_n;
  logic [swdr_pkg::ST_W-1:0]  st_new;
  logic [CW-1:0]              cnt_new;
  logic [DATA_WIDTH-1:0]      rv_new;
  logic                       full, empty;
  logic [XW-1:0]              cnt_x, off_x, ra_x, wa_x;
  logic [DATA_WIDTH-1:0]      wdata, rdata;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign cnt_x = XW'(count_r);
  assign off_x = XW'(off_r);

  always_comb begin
    rd_n    = 2'd0;
    wr_n    = 2'd0;
    st_new  = swdr_pkg::ST_OK;
    cnt_new = count_r;
    rv_new  = '0;
    case (op_r)
      swdr_pkg::OP_PUSH: begin
        if (full) begin
          st_new = swdr_pkg::ST_OVER;
        end else begin
          wr_n    = 2'd1;
          cnt_new = count_r + CW'(1);
        end
      end
      swdr_pkg::OP_POP: begin
        if (empty) begin
          st_new = swdr_pkg::ST_UNDER;
        end else begin
          rd_n    = 2'd1;
          cnt_new = count_r - CW'(1);
          rv_new  = w_r[0];
        end
      end
      swdr_pkg::OP_DUP: begin
        if (empty) begin
          st_new = swdr_pkg::ST_UNDER;
        end else if (full) begin
          st_new = swdr_pkg::ST_OVER;
        end else begin
          rd_n    = 2'd1;
          wr_n    = 2'd1;
          cnt_new = count_r + CW'(1);
        end
      end
      swdr_pkg::OP_SWAP: begin
        if (count_r < CW'(2)) begin
          st_new = swdr_pkg::ST_UNDER;
        end else begin
          rd_n = 2'd2;
          wr_n = 2'd2;
        end
      end
      swdr_pkg::OP_ROT: begin
        if (count_r < CW'(3)) begin
          st_new = swdr_pkg::ST_UNDER;
        end else begin
          rd_n = 2'd3;
          wr_n = 2'd3;
        end
      end
      swdr_pkg::OP_PEEK: begin
        if (off_x >= cnt_x) begin
          st_new = swdr_pkg::ST_UNDER;
        end else begin
          rd_n   = 2'd1;
          rv_new = w_r[0];
        end
      end
      default: begin
        st_new = swdr_pkg::ST_UNDER;
      end
    endcase
  end

  always_comb begin
    if (op_r == swdr_pkg::OP_PEEK) begin
      ra_x = cnt_x - XW'(1) - off_x;
    end else begin
      ra_x = cnt_x - XW'(1) - XW'(step_r);
    end
  end

  always_comb begin
    wa_x  = cnt_x;
    wdata = w_r[0];
    case (op_r)
      swdr_pkg::OP_PUSH: begin
        wdata = val_r;
      end
      swdr_pkg::OP_SWAP: begin
        if (step_r == 2'd0) begin
          wa_x  = cnt_x - XW'(1);
          wdata = w_r[1];
        end else begin
          wa_x  = cnt_x - XW'(2);
          wdata = w_r[0];
        end
      end
      swdr_pkg::OP_ROT: begin
        if (step_r == 2'd0) begin
          wa_x  = cnt_x - XW'(3);
          wdata = w_r[1];
        end else if (step_r == 2'd1) begin
          wa_x  = cnt_x - XW'(2);
          wdata = w_r[0];
        end else begin
          wa_x  = cnt_x - XW'(1);
          wdata = w_r[2];
        end
      end
      default: begin
        wa_x  = cnt_x;
        wdata = w_r[0];
      end
    endcase
  end

  assign sts.has_read   = (rd_n != 2'd0);
  assign sts.has_write  = (wr_n != 2'd0);
  assign sts.last_read  = (step_r == rd_n - 2'd1);
  assign sts.last_write = (step_r == wr_n - 2'd1);

  swdr_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (wa_x[AW-1:0]),
    .wdata (wdata),
    .re    (cmd.rd_issue),
    .raddr (ra_x[AW-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      step_r  <= 2'd0;
    end else begin
      if (cmd.finish) begin
        count_r <= cnt_new;
      end
      if (cmd.step_clr) begin
        step_r <= 2'd0;
      end else if (cmd.step_inc) begin
        step_r <= step_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_opcode;
      val_r <= in_push_value;
      off_r <= in_peek_offset;
    end
    if (cmd.rd_latch) begin
      w_r[step_r] <= rdata;
    end
    if (cmd.finish) begin
      rv_r <= rv_new;
      st_r <= st_new;
    end
  end

  assign out_read_value = rv_r;
  assign out_status     = st_r;
  assign out_item_count = count_r;

endmodule

`default_nettype wire

### hw/rtl/stack_with_dup_swap_rot.sv
// Each operation makes R reads and W writes on the stack memory, which has one read port
// and one write port (rot: 3 and 3; a failed operation makes none). A new input beat
// is taken only in S_IDLE, after the previous operation has finished in S_DONE.
// Each memory read goes through an issue state and a capture state; each write is made in S_WRITE.
// Reset clears the item count and out_valid; memory and result data are not cleared.
`default_nettype none

module stack_with_dup_swap_rot #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [swdr_pkg::OP_W-1:0]     in_opcode,
  input  wire logic [DATA_WIDTH-1:0]         in_push_value,
  input  wire logic [swdr_pkg::OFF_W-1:0]    in_peek_offset,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [DATA_WIDTH-1:0]         out_read_value,
  output logic      [swdr_pkg::ST_W-1:0]     out_status,
  output logic      [$clog2(DEPTH+1)-1:0]    out_item_count
);

  swdr_pkg::cmd_t cmd;
  swdr_pkg::sts_t sts;

  swdr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  swdr_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_opcode      (in_opcode),
    .in_push_value  (in_push_value),
    .in_peek_offset (in_peek_offset),
    .out_read_value (out_read_value),
    .out_status     (out_status),
    .out_item_count (out_item_count)
  );

endmodule

`default_nettype wire

### hw/rtl/swdr_chk.sv
`default_nettype none
`include "stack_with_dup_swap_rot_macros.svh"

module swdr_chk #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [DATA_WIDTH-1:0]         out_read_value,
  input wire logic [swdr_pkg::ST_W-1:0]     out_status,
  input wire logic [$clog2(DEPTH+1)-1:0]    out_item_count
);

  localparam int CW = $clog2(DEPTH + 1);

  logic in_beat, out_stall, out_fail, out_over;

  assign in_beat   = in_valid && in_ready;
  assign out_stall = out_valid && !out_ready;
  assign out_fail  = out_valid && (out_status != swdr_pkg::ST_OK);
  assign out_over  = out_valid && (out_status == swdr_pkg::ST_OVER);

  `SWDR_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_read_value), "beat lost")
  `SWDR_ASSERT_NEXT(a_one_at_a_time, in_beat, !in_ready, "beat taken while busy")
  `SWDR_ASSERT_SAME(a_fail_zero, out_fail, out_read_value == '0, "data on failure")
  `SWDR_ASSERT_SAME(a_over_full, out_over, out_item_count == CW'(DEPTH), "overflow not full")
  `SWDR_ASSERT_SAME(a_count_range, out_valid, out_item_count <= CW'(DEPTH), "count past depth")

endmodule

bind stack_with_dup_swap_rot swdr_chk #(
  .DEPTH      (DEPTH),
  .DATA_WIDTH (DATA_WIDTH)
) u_swdr_chk (.*);

`default_nettype wire
